/* rtl/dibht_pkg.sv */
`default_nettype none
package dibht_pkg;

	localparam logic [31:0] HASH_MULT = 32'd2654435769;

	typedef enum logic [2:0] {
		OP_INSERT      = 3'd0,
		OP_FIND_SIZE   = 3'd1,
		OP_FIND_OFFSET = 3'd2,
		OP_SET_USE     = 3'd3,
		OP_REMOVE      = 3'd4
	} op_t;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_NOT_FOUND = 2'd1,
		ST_INVALID   = 2'd2,
		ST_FULL      = 2'd3
	} status_t;

	typedef enum logic [2:0] {
		K_INSERT,
		K_FIND,
		K_SET,
		K_REMOVE,
		K_ERROR
	} kind_t;

	typedef struct packed {
		kind_t       kind;
		logic        by_size;
		logic        match_use;
		logic [31:0] offset;
		logic [31:0] size;
		logic        use_flag;
		logic [63:0] tag;
	} cmd_t;

	typedef struct packed {
		logic [31:0] offset;
		logic [31:0] size;
		logic        in_use;
		logic [63:0] tag;
	} rec_t;

endpackage
`default_nettype wire

/* rtl/dibht_ram.sv */
`default_nettype none
module dibht_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule
`default_nettype wire

/* rtl/dibht_front.sv */
`default_nettype none
module dibht_front #(
	parameter int BW = 6,
	parameter int LB = 6
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_ready,
	input  wire logic [2:0]        op,
	input  wire logic [31:0]       block_offset,
	input  wire logic [31:0]       block_size,
	input  wire logic              in_use_flag,
	input  wire logic [63:0]       tag,
	output logic                   q_valid,
	input  wire logic              q_ready,
	output dibht_pkg::cmd_t        q_cmd,
	output logic [BW-1:0]          q_bo,
	output logic [BW-1:0]          q_bs
);

	logic        vld_s1;
	logic [2:0]  op_s1;
	logic [31:0] off_s1;
	logic [31:0] sz_s1;
	logic        use_s1;
	logic [63:0] tag_s1;

	dibht_pkg::cmd_t cmd_w;
	logic [31:0]     prod_o;
	logic [31:0]     prod_s;
	logic            push;
	logic            pop;

	dibht_pkg::cmd_t fifo_cmd_q [2];
	logic [BW-1:0]   fifo_bo_q [2];
	logic [BW-1:0]   fifo_bs_q [2];
	logic            wp_q;
	logic            rp_q;
	logic [1:0]      cnt_q;

	assign push     = vld_s1 && (cnt_q != 2'd2);
	assign in_ready = !vld_s1 || push;
	assign q_valid  = (cnt_q != 2'd0);
	assign pop      = q_valid && q_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= (in_valid && in_ready) || (vld_s1 && !push);
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			op_s1  <= op;
			off_s1 <= block_offset;
			sz_s1  <= block_size;
			use_s1 <= in_use_flag;
			tag_s1 <= tag;
		end
	end

	// classify
	always_comb begin
		cmd_w.offset    = off_s1;
		cmd_w.size      = sz_s1;
		cmd_w.use_flag  = use_s1;
		cmd_w.tag       = tag_s1;
		cmd_w.match_use = 1'b0;
		cmd_w.by_size   = 1'b0;
		cmd_w.kind      = dibht_pkg::K_ERROR;
		case (op_s1)
			dibht_pkg::OP_INSERT: begin
				cmd_w.kind = dibht_pkg::K_INSERT;
			end
			dibht_pkg::OP_FIND_SIZE: begin
				cmd_w.kind      = dibht_pkg::K_FIND;
				cmd_w.by_size   = 1'b1;
				cmd_w.match_use = 1'b1;
			end
			dibht_pkg::OP_FIND_OFFSET: begin
				cmd_w.kind      = dibht_pkg::K_FIND;
				cmd_w.match_use = 1'b1;
			end
			dibht_pkg::OP_SET_USE, dibht_pkg::OP_REMOVE: begin
				cmd_w.by_size = (off_s1 == 32'd0);
				if ((off_s1 == 32'd0) != (sz_s1 == 32'd0)) begin
					cmd_w.kind = (op_s1 == dibht_pkg::OP_SET_USE) ?
						dibht_pkg::K_SET : dibht_pkg::K_REMOVE;
				end
			end
			default: begin
				cmd_w.kind = dibht_pkg::K_ERROR;
			end
		endcase
	end

	assign prod_o = off_s1 * dibht_pkg::HASH_MULT;
	assign prod_s = sz_s1 * dibht_pkg::HASH_MULT;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) begin
				wp_q <= !wp_q;
			end
			if (pop) begin
				rp_q <= !rp_q;
			end
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			fifo_cmd_q[wp_q] <= cmd_w;
			fifo_bo_q[wp_q]  <= BW'(prod_o >> (32 - LB));
			fifo_bs_q[wp_q]  <= BW'(prod_s >> (32 - LB));
		end
	end

	assign q_cmd = fifo_cmd_q[rp_q];
	assign q_bo  = fifo_bo_q[rp_q];
	assign q_bs  = fifo_bs_q[rp_q];

endmodule
`default_nettype wire

/* rtl/dibht_back.sv */
`default_nettype none
module dibht_back #(
	parameter int CAPACITY = 256,
	parameter int BUCKETS  = 64,
	parameter int BW       = 6,
	parameter int LB       = 6
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              q_valid,
	output logic                   q_ready,
	input  wire dibht_pkg::cmd_t   q_cmd,
	input  wire logic [BW-1:0]     q_bo,
	input  wire logic [BW-1:0]     q_bs,
	output logic                   out_valid,
	input  wire logic              out_ready,
	output logic [1:0]             status,
	output logic [31:0]            found_offset,
	output logic [31:0]            found_size,
	output logic                   found_in_use,
	output logic [63:0]            found_tag
);

	localparam int IW = $clog2(CAPACITY);
	localparam int PW = $clog2(CAPACITY + 1);
	localparam int NG = (CAPACITY + 7) / 8;
	localparam int GW = (NG > 1) ? $clog2(NG) : 1;
	localparam logic [PW-1:0] NIL = PW'(CAPACITY);

	typedef enum logic [3:0] {
		S_IDLE, S_DISP, S_SCAN, S_IWR, S_HASH, S_BKT,
		S_HWAIT, S_HEAD, S_CHK, S_CMP, S_RESP
	} state_t;

	state_t             state_q;
	dibht_pkg::cmd_t    cmd_q;
	logic [BW-1:0]      bo_q;
	logic [BW-1:0]      bs_q;
	logic               csel_q;
	logic               unl_q;
	logic [PW-1:0]      cur_q;
	logic [PW-1:0]      prev_q;
	logic [IW-1:0]      idx_q;
	logic [GW-1:0]      grp_q;
	logic [31:0]        hprod_q;
	logic [PW-1:0]      count_q;
	logic [CAPACITY-1:0] valid_q;
	logic [BUCKETS-1:0] hvld_o_q;
	logic [BUCKETS-1:0] hvld_s_q;
	dibht_pkg::status_t res_st_q;
	dibht_pkg::rec_t    res_q;
	dibht_pkg::status_t out_st_q;
	dibht_pkg::rec_t    out_q;
	logic               out_valid_q;

	logic [NG*8-1:0]    vpad;
	logic [7:0]         gbits;
	logic               gfound;
	logic [2:0]         gpos;
	logic [GW+2:0]      fidx_w;
	logic [IW-1:0]      free_idx;

	dibht_pkg::rec_t    rec_rd;
	dibht_pkg::rec_t    rec_wdata;
	logic               rec_we;
	logic [IW-1:0]      rec_waddr;
	logic [PW-1:0]      olink_rd;
	logic [PW-1:0]      slink_rd;
	logic [PW-1:0]      ohead_rd;
	logic [PW-1:0]      shead_rd;
	logic [PW-1:0]      head_o_eff;
	logic [PW-1:0]      head_s_eff;
	logic [PW-1:0]      link_rd;
	logic [31:0]        ckey;
	logic [31:0]        skey;
	logic               hit;
	logic               unlink;
	logic               olink_we;
	logic [IW-1:0]      olink_waddr;
	logic [PW-1:0]      olink_wdata;
	logic               slink_we;
	logic [IW-1:0]      slink_waddr;
	logic [PW-1:0]      slink_wdata;
	logic               ohead_we;
	logic [PW-1:0]      ohead_wdata;
	logic               shead_we;
	logic [PW-1:0]      shead_wdata;
	logic [BW-1:0]      hbucket;

	assign q_ready      = (state_q == S_IDLE);
	assign out_valid    = out_valid_q;
	assign status       = out_st_q;
	assign found_offset = out_q.offset;
	assign found_size   = out_q.size;
	assign found_in_use = out_q.in_use;
	assign found_tag    = out_q.tag;

	// free slot scan, eight slots per cycle
	always_comb begin
		vpad = '1;
		vpad[CAPACITY-1:0] = valid_q;
		gbits  = vpad[grp_q*8 +: 8];
		gfound = 1'b0;
		gpos   = 3'd0;
		for (int i = 7; i >= 0; i--) begin
			if (!gbits[i]) begin
				gfound = 1'b1;
				gpos   = 3'(i);
			end
		end
	end
	assign fidx_w   = {grp_q, gpos};
	assign free_idx = fidx_w[IW-1:0];

	assign head_o_eff = hvld_o_q[bo_q] ? ohead_rd : NIL;
	assign head_s_eff = hvld_s_q[bs_q] ? shead_rd : NIL;
	assign link_rd    = csel_q ? slink_rd : olink_rd;
	assign ckey       = csel_q ? rec_rd.size : rec_rd.offset;
	assign skey       = csel_q ? cmd_q.size : cmd_q.offset;
	assign hit        = unl_q ? (cur_q == PW'(idx_q)) :
		((ckey == skey) && (!cmd_q.match_use || (rec_rd.in_use == cmd_q.use_flag)));
	assign unlink     = (state_q == S_CMP) && hit &&
		(unl_q || (cmd_q.kind == dibht_pkg::K_REMOVE));
	assign hbucket    = BW'(hprod_q >> (32 - LB));

	always_comb begin
		rec_we      = 1'b0;
		rec_waddr   = cur_q[IW-1:0];
		rec_wdata   = rec_rd;
		olink_we    = 1'b0;
		olink_waddr = prev_q[IW-1:0];
		olink_wdata = link_rd;
		slink_we    = 1'b0;
		slink_waddr = prev_q[IW-1:0];
		slink_wdata = link_rd;
		ohead_we    = 1'b0;
		ohead_wdata = link_rd;
		shead_we    = 1'b0;
		shead_wdata = link_rd;
		if (state_q == S_IWR) begin
			rec_we           = 1'b1;
			rec_waddr        = idx_q;
			rec_wdata.offset = cmd_q.offset;
			rec_wdata.size   = cmd_q.size;
			rec_wdata.in_use = cmd_q.use_flag;
			rec_wdata.tag    = cmd_q.tag;
			olink_we         = 1'b1;
			olink_waddr      = idx_q;
			olink_wdata      = head_o_eff;
			slink_we         = 1'b1;
			slink_waddr      = idx_q;
			slink_wdata      = head_s_eff;
			ohead_we         = 1'b1;
			ohead_wdata      = PW'(idx_q);
			shead_we         = 1'b1;
			shead_wdata      = PW'(idx_q);
		end else if ((state_q == S_CMP) && hit && !unl_q &&
				(cmd_q.kind == dibht_pkg::K_SET)) begin
			rec_we           = 1'b1;
			rec_wdata.in_use = cmd_q.use_flag;
		end else if (unlink) begin
			if (prev_q == NIL) begin
				ohead_we = !csel_q;
				shead_we = csel_q;
			end else begin
				olink_we = !csel_q;
				slink_we = csel_q;
			end
		end
	end

	dibht_ram #(.WIDTH($bits(dibht_pkg::rec_t)), .DEPTH(CAPACITY)) u_rec (
		.clk(clk), .we(rec_we), .waddr(rec_waddr), .wdata(rec_wdata),
		.raddr(cur_q[IW-1:0]), .rdata(rec_rd)
	);

	dibht_ram #(.WIDTH(PW), .DEPTH(CAPACITY)) u_olink (
		.clk(clk), .we(olink_we), .waddr(olink_waddr), .wdata(olink_wdata),
		.raddr(cur_q[IW-1:0]), .rdata(olink_rd)
	);

	dibht_ram #(.WIDTH(PW), .DEPTH(CAPACITY)) u_slink (
		.clk(clk), .we(slink_we), .waddr(slink_waddr), .wdata(slink_wdata),
		.raddr(cur_q[IW-1:0]), .rdata(slink_rd)
	);

	dibht_ram #(.WIDTH(PW), .DEPTH(BUCKETS)) u_ohead (
		.clk(clk), .we(ohead_we), .waddr(bo_q), .wdata(ohead_wdata),
		.raddr(bo_q), .rdata(ohead_rd)
	);

	dibht_ram #(.WIDTH(PW), .DEPTH(BUCKETS)) u_shead (
		.clk(clk), .we(shead_we), .waddr(bs_q), .wdata(shead_wdata),
		.raddr(bs_q), .rdata(shead_rd)
	);

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (q_valid) begin
					cmd_q <= q_cmd;
					bo_q  <= q_bo;
					bs_q  <= q_bs;
				end
			end
			S_SCAN: begin
				idx_q <= free_idx;
			end
			S_HASH: begin
				hprod_q <= (csel_q ? res_q.size : res_q.offset) * dibht_pkg::HASH_MULT;
			end
			S_BKT: begin
				if (csel_q) begin
					bs_q <= hbucket;
				end else begin
					bo_q <= hbucket;
				end
			end
			S_CMP: begin
				if (hit && !unl_q) begin
					idx_q <= cur_q[IW-1:0];
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			csel_q      <= 1'b0;
			unl_q       <= 1'b0;
			cur_q       <= NIL;
			prev_q      <= NIL;
			grp_q       <= '0;
			count_q     <= '0;
			valid_q     <= '0;
			hvld_o_q    <= '0;
			hvld_s_q    <= '0;
			res_st_q    <= dibht_pkg::ST_OK;
			res_q       <= '0;
			out_st_q    <= dibht_pkg::ST_OK;
			out_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && out_ready && (state_q != S_RESP)) begin
				out_valid_q <= 1'b0;
			end
			if (ohead_we) begin
				hvld_o_q[bo_q] <= 1'b1;
			end
			if (shead_we) begin
				hvld_s_q[bs_q] <= 1'b1;
			end
			case (state_q)
				S_IDLE: begin
					if (q_valid) begin
						csel_q  <= q_cmd.by_size;
						unl_q   <= 1'b0;
						state_q <= S_DISP;
					end
				end
				S_DISP: begin
					res_q <= '0;
					case (cmd_q.kind)
						dibht_pkg::K_ERROR: begin
							res_st_q <= dibht_pkg::ST_INVALID;
							state_q  <= S_RESP;
						end
						dibht_pkg::K_INSERT: begin
							if (count_q == PW'(CAPACITY)) begin
								res_st_q <= dibht_pkg::ST_FULL;
								state_q  <= S_RESP;
							end else begin
								res_st_q <= dibht_pkg::ST_OK;
								grp_q    <= '0;
								state_q  <= S_SCAN;
							end
						end
						default: begin
							res_st_q <= dibht_pkg::ST_OK;
							state_q  <= S_HEAD;
						end
					endcase
				end
				S_SCAN: begin
					if (gfound) begin
						state_q <= S_IWR;
					end else begin
						grp_q <= grp_q + 1'b1;
					end
				end
				S_IWR: begin
					valid_q[idx_q] <= 1'b1;
					count_q        <= count_q + 1'b1;
					state_q        <= S_RESP;
				end
				S_HASH: begin
					state_q <= S_BKT;
				end
				S_BKT: begin
					state_q <= S_HWAIT;
				end
				S_HWAIT: begin
					state_q <= S_HEAD;
				end
				S_HEAD: begin
					cur_q   <= csel_q ? head_s_eff : head_o_eff;
					prev_q  <= NIL;
					state_q <= S_CHK;
				end
				S_CHK: begin
					if (cur_q == NIL) begin
						if (!unl_q) begin
							res_st_q <= dibht_pkg::ST_NOT_FOUND;
							res_q    <= '0;
						end
						state_q <= S_RESP;
					end else begin
						state_q <= S_CMP;
					end
				end
				S_CMP: begin
					if (!hit) begin
						prev_q  <= cur_q;
						cur_q   <= link_rd;
						state_q <= S_CHK;
					end else if (unl_q) begin
						valid_q[idx_q] <= 1'b0;
						count_q        <= count_q - 1'b1;
						state_q        <= S_RESP;
					end else begin
						case (cmd_q.kind)
							dibht_pkg::K_SET: begin
								res_q   <= '{rec_rd.offset, rec_rd.size, cmd_q.use_flag,
									rec_rd.tag};
								state_q <= S_RESP;
							end
							dibht_pkg::K_REMOVE: begin
								res_q   <= rec_rd;
								csel_q  <= !csel_q;
								unl_q   <= 1'b1;
								state_q <= S_HASH;
							end
							default: begin
								res_q   <= rec_rd;
								state_q <= S_RESP;
							end
						endcase
					end
				end
				S_RESP: begin
					if (!out_valid_q || out_ready) begin
						out_valid_q <= 1'b1;
						out_st_q    <= res_st_q;
						out_q       <= res_q;
						state_q     <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule
`default_nettype wire

/* rtl/dual_index_block_hash_table_top.sv */
// operation: find and set read the bucket head and walk one chain node by node; remove walks
// both chains, rehashing the record's other key between the two walks; insert scans the valid
// bits for a free slot, eight valid bits per cycle
// throughput: one request at a time in the back end, chain walk reads one node at a time
// through the registered record and link memories
// reset: asynchronous, clears valid bits, bucket head valid bits and the count; no sweep
`default_nettype none
module dual_index_block_hash_table_top #(
	parameter int CAPACITY = 256,
	parameter int BUCKETS  = 64
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [2:0]  op,
	input  wire logic [31:0] block_offset,
	input  wire logic [31:0] block_size,
	input  wire logic        in_use_flag,
	input  wire logic [63:0] tag,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [1:0]       status,
	output logic [31:0]      found_offset,
	output logic [31:0]      found_size,
	output logic             found_in_use,
	output logic [63:0]      found_tag
);

	localparam int BW = $clog2(BUCKETS);
	localparam int LB = $clog2(BUCKETS + 1) - 1;

	logic            q_valid;
	logic            q_ready;
	dibht_pkg::cmd_t q_cmd;
	logic [BW-1:0]   q_bo;
	logic [BW-1:0]   q_bs;

	dibht_front #(.BW(BW), .LB(LB)) u_front (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.op(op), .block_offset(block_offset), .block_size(block_size),
		.in_use_flag(in_use_flag), .tag(tag),
		.q_valid(q_valid), .q_ready(q_ready), .q_cmd(q_cmd), .q_bo(q_bo), .q_bs(q_bs)
	);

	dibht_back #(.CAPACITY(CAPACITY), .BUCKETS(BUCKETS), .BW(BW), .LB(LB)) u_back (
		.clk(clk), .arst_n(arst_n),
		.q_valid(q_valid), .q_ready(q_ready), .q_cmd(q_cmd), .q_bo(q_bo), .q_bs(q_bs),
		.out_valid(out_valid), .out_ready(out_ready), .status(status),
		.found_offset(found_offset), .found_size(found_size),
		.found_in_use(found_in_use), .found_tag(found_tag)
	);

endmodule
`default_nettype wire

/* rtl/dibht_checker.sv */
`default_nettype none
module dibht_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        in_valid,
	input wire logic        in_ready,
	input wire logic [2:0]  op,
	input wire logic [31:0] block_offset,
	input wire logic [31:0] block_size,
	input wire logic        in_use_flag,
	input wire logic [63:0] tag,
	input wire logic        out_valid,
	input wire logic        out_ready,
	input wire logic [1:0]  status,
	input wire logic [31:0] found_offset,
	input wire logic [31:0] found_size,
	input wire logic        found_in_use,
	input wire logic [63:0] found_tag
);

	logic [2:0] pend_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= 3'd0;
		end else begin
			pend_q <= pend_q + {2'd0, in_valid && in_ready} - {2'd0, out_valid && out_ready};
		end
	end

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(status) && $stable(found_tag)
			&& $stable(found_offset) && $stable(found_size))
		else $error("result changed while stalled");

	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status != dibht_pkg::ST_OK) |->
			found_offset == 32'd0 && found_size == 32'd0 && !found_in_use
			&& found_tag == 64'd0)
		else $error("failed request carries record fields");

	a_no_orphan: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> pend_q != 3'd0)
		else $error("result without pending request");

endmodule

bind dual_index_block_hash_table_top dibht_checker u_chk (.*);
`default_nettype wire
